// ===== sv/mcr_pkg.sv =====
// ---------------------------------------------------------------------------
// mcr_pkg
// Shared codes and constants of the midpoint circle rasterizer.
// ---------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

   // command carried in req_tuser
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // eight symmetric points per step
   localparam int unsigned OCT_W = 3;
   localparam logic [OCT_W-1:0] OCT_FIRST = 3'd0;
   localparam logic [OCT_W-1:0] OCT_LAST  = 3'd7;

endpackage : mcr_pkg

`default_nettype wire

// ===== sv/mcr_front.sv =====
// ---------------------------------------------------------------------------
// mcr_front
// Takes start and step items, runs the midpoint walk one step per item and
// posts each step's centre, (x, y) and done flag as a job.
// ---------------------------------------------------------------------------
`default_nettype none

module mcr_front #(
   parameter int unsigned COORD_BITS  = 16,
   parameter int unsigned RADIUS_BITS = 12,
   parameter int unsigned JOB_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_valid,
   output logic                         item_ready,
   input  logic                         cmd,
   input  logic signed [COORD_BITS-1:0] center_x,
   input  logic signed [COORD_BITS-1:0] center_y,
   input  logic [RADIUS_BITS-1:0]       radius,
   output logic                         job_push,
   output logic [JOB_W-1:0]             job_data,
   input  logic                         job_full
);
   import mcr_pkg::*;

   localparam int unsigned R     = RADIUS_BITS;
   localparam int unsigned ERR_W = RADIUS_BITS + 4;

   logic                         active_ff, active_in;
   logic signed [COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [R:0]                   diam_ff, diam_in;
   logic signed [R:0]            wx_ff, wx_in;
   logic [R-1:0]                 wy_ff, wy_in;
   logic [R+1:0]                 tx_ff, tx_in, ty_ff, ty_in;
   logic signed [ERR_W-1:0]      err_ff, err_in;

   logic                         accept;
   logic signed [ERR_W-1:0]      e1, e2;
   logic signed [R:0]            x1;
   logic [R-1:0]                 y1;
   logic [R+1:0]                 tx1, ty1;
   logic                         done;

   assign item_ready = !job_full;
   assign accept     = item_valid && item_ready;

   // one midpoint step
   always_comb begin
      y1  = wy_ff;
      ty1 = ty_ff;
      e1  = err_ff;
      if (err_ff <= 0) begin
         y1  = wy_ff + 1'b1;
         e1  = err_ff + $signed({{(ERR_W-R-2){1'b0}}, ty_ff});
         ty1 = ty_ff + (R+2)'(2);
      end
      x1  = wx_ff;
      tx1 = tx_ff;
      e2  = e1;
      if (e1 > 0) begin
         x1  = wx_ff - 1'b1;
         tx1 = tx_ff + (R+2)'(2);
         e2  = e1 + $signed({{(ERR_W-R-2){1'b0}}, tx1})
                  - $signed({{(ERR_W-R-1){1'b0}}, diam_ff});
      end
      done = $signed({x1[R], x1}) < $signed({2'b00, y1});
   end

   always_comb begin
      active_in = active_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      diam_in   = diam_ff;
      wx_in     = wx_ff;
      wy_in     = wy_ff;
      tx_in     = tx_ff;
      ty_in     = ty_ff;
      err_in    = err_ff;
      job_push  = 1'b0;
      if (accept) begin
         if (cmd == CMD_START) begin
            cx_in     = center_x;
            cy_in     = center_y;
            diam_in   = {radius, 1'b0};
            wx_in     = $signed({1'b0, radius}) - $signed((R+1)'(1));
            wy_in     = '0;
            tx_in     = (R+2)'(1);
            ty_in     = (R+2)'(1);
            err_in    = ERR_W'(1) - $signed({{(ERR_W-R-1){1'b0}}, radius, 1'b0});
            active_in = (radius != '0);
         end else if (active_ff) begin
            wx_in     = x1;
            wy_in     = y1;
            tx_in     = tx1;
            ty_in     = ty1;
            err_in    = e2;
            active_in = !done;
            job_push  = 1'b1;
         end
      end
   end

   // job: {done, y, x, cy, cx}
   assign job_data = {done, wy_ff, wx_ff, cy_ff, cx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      diam_ff <= diam_in;
      wx_ff   <= wx_in;
      wy_ff   <= wy_in;
      tx_ff   <= tx_in;
      ty_ff   <= ty_in;
      err_ff  <= err_in;
   end

endmodule : mcr_front

`default_nettype wire

// ===== sv/mcr_queue.sv =====
// ---------------------------------------------------------------------------
// mcr_queue
// Short first-in first-out job queue between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module mcr_queue #(
   parameter int unsigned WIDTH = 58,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule : mcr_queue

`default_nettype wire

// ===== sv/mcr_back.sv =====
// ---------------------------------------------------------------------------
// mcr_back
// Expands each job into its eight symmetric points, one per cycle while the
// output is not stalled, into an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module mcr_back #(
   parameter int unsigned COORD_BITS  = 16,
   parameter int unsigned RADIUS_BITS = 12,
   parameter int unsigned JOB_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  job_valid,
   input  logic [JOB_W-1:0]                      job_data,
   output logic                                  job_pop,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [COORD_BITS:0]            point_x,
   output logic signed [COORD_BITS:0]            point_y,
   output logic [mcr_pkg::OCT_W-1:0]             octant,
   output logic                                  last_of_run,
   output logic                                  circle_done
);
   import mcr_pkg::*;

   localparam int unsigned C     = COORD_BITS;
   localparam int unsigned R     = RADIUS_BITS;
   localparam int unsigned SUM_W = ((C > R + 1) ? C : R + 1) + 2;

   logic signed [C-1:0]     j_cx, j_cy;
   logic signed [R:0]       j_x;
   logic [R-1:0]            j_y;
   logic                    j_done;
   logic signed [SUM_W-1:0] ex_cx, ex_cy, ex_x, ex_y, a, b, px, py;

   logic [OCT_W-1:0]        k_ff, k_in;
   logic                    valid_ff, valid_in;
   logic signed [C:0]       px_ff, px_in, py_ff, py_in;
   logic [OCT_W-1:0]        oct_ff, oct_in;
   logic                    last_ff, last_in, done_ff, done_in;
   logic                    load;

   assign {j_done, j_y, j_x, j_cy, j_cx} = job_data;

   assign ex_cx = SUM_W'(j_cx);
   assign ex_cy = SUM_W'(j_cy);
   assign ex_x  = SUM_W'(j_x);
   assign ex_y  = $signed({{(SUM_W-R){1'b0}}, j_y});

   // bit 2 swaps x and y, bit 1 negates the x offset, bit 0 picks +y side
   assign a  = k_ff[2] ? ex_y : ex_x;
   assign b  = k_ff[2] ? ex_x : ex_y;
   assign px = k_ff[1] ? ex_cx - a : ex_cx + a;
   assign py = k_ff[0] ? ex_cy + b : ex_cy - b;

   assign load    = job_valid && (!valid_ff || out_ready);
   assign job_pop = load && (k_ff == OCT_LAST);

   always_comb begin
      k_in     = k_ff;
      valid_in = valid_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      oct_in   = oct_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      if (load) begin
         valid_in = 1'b1;
         px_in    = px[C:0];
         py_in    = py[C:0];
         oct_in   = k_ff;
         last_in  = (k_ff == OCT_LAST);
         done_in  = (k_ff == OCT_LAST) && j_done;
         k_in     = (k_ff == OCT_LAST) ? OCT_FIRST : k_ff + 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= OCT_FIRST;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
      px_ff   <= px_in;
      py_ff   <= py_in;
      oct_ff  <= oct_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign out_valid   = valid_ff;
   assign point_x     = px_ff;
   assign point_y     = py_ff;
   assign octant      = oct_ff;
   assign last_of_run = last_ff;
   assign circle_done = done_ff;

endmodule : mcr_back

`default_nettype wire

// ===== sv/midpoint_circle_rasterizer_top.sv =====
// ---------------------------------------------------------------------------
// midpoint_circle_rasterizer_top
// Integer midpoint circle rasterizer: start items load a circle, step items
// each give the eight symmetric points of one walk step.
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake           payload
//  req_     in   tvalid/tready       tdata: center_x, center_y, radius
//                                    tuser: cmd (0 start, 1 step)
//  rsp_     out  tvalid/tready       tdata: point_x, point_y
//                                    tuser: octant, circle_done
//                                    tlast: last_of_run
//
//  The front takes one item per cycle while the job queue is not full and
//  advances the walk in that cycle; each live step becomes a job in a
//  two-deep queue. The back turns a job into eight points, one per cycle
//  while rsp_tready is high, so a steady stream of steps is paced by the
//  output port. Start items and steps on a finished circle give no items
//  and are taken by the front only.
//  req_tready drops only while the job queue is full; a stalled rsp_ side
//  holds its register and backs up into the queue.
//  Reset is synchronous, active high, and clears the walk's active flag,
//  the queue and the output valid; a start item loads the rest of the walk.
//
`default_nettype none

module midpoint_circle_rasterizer_top #(
   parameter int unsigned COORD_BITS  = 16,
   parameter int unsigned RADIUS_BITS = 12
) (
   input  logic                                             clock,
   input  logic                                             reset,
   // center_x, center_y, radius (lowest first), zero padded
   input  logic [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0]    req_tdata,
   // cmd
   input  logic                                             req_tuser,
   input  logic                                             req_tvalid,
   output logic                                             req_tready,
   // point_x, point_y (lowest first), zero padded
   output logic [((2*COORD_BITS+2+7)/8)*8-1:0]              rsp_tdata,
   // octant, circle_done (lowest first)
   output logic [mcr_pkg::OCT_W:0]                          rsp_tuser,
   output logic                                             rsp_tlast,
   output logic                                             rsp_tvalid,
   input  logic                                             rsp_tready
);
   import mcr_pkg::*;

   localparam int unsigned C      = COORD_BITS;
   localparam int unsigned R      = RADIUS_BITS;
   localparam int unsigned JOB_W  = 2 * C + 2 * R + 2;
   localparam int unsigned OUT_W  = ((2 * C + 2 + 7) / 8) * 8;
   localparam int unsigned QDEPTH = 2;

   logic signed [C-1:0] center_x, center_y;
   logic [R-1:0]        radius;
   logic                job_push, job_full, job_valid, job_pop;
   logic [JOB_W-1:0]    job_in, job_head;
   logic signed [C:0]   point_x, point_y;
   logic [OCT_W-1:0]    octant;
   logic                circle_done;

   // padding bits of req_tdata above radius are not looked at
   assign center_x = req_tdata[C-1:0];
   assign center_y = req_tdata[2*C-1:C];
   assign radius   = req_tdata[2*C+R-1:2*C];

   mcr_front #(
      .COORD_BITS  (C),
      .RADIUS_BITS (R),
      .JOB_W       (JOB_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .cmd        (req_tuser),
      .center_x   (center_x),
      .center_y   (center_y),
      .radius     (radius),
      .job_push   (job_push),
      .job_data   (job_in),
      .job_full   (job_full)
   );

   mcr_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_in),
      .full       (job_full),
      .pop        (job_pop),
      .head_valid (job_valid),
      .head_data  (job_head)
   );

   mcr_back #(
      .COORD_BITS  (C),
      .RADIUS_BITS (R),
      .JOB_W       (JOB_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job_data    (job_head),
      .job_pop     (job_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .point_x     (point_x),
      .point_y     (point_y),
      .octant      (octant),
      .last_of_run (rsp_tlast),
      .circle_done (circle_done)
   );

   assign rsp_tdata = OUT_W'({point_y, point_x});
   assign rsp_tuser = {circle_done, octant};

endmodule : midpoint_circle_rasterizer_top

`default_nettype wire

// ===== test/midpoint_circle_rasterizer_top_test.sv =====
// ---------------------------------------------------------------------------
// midpoint_circle_rasterizer_top_test
// Self-checking bench for the midpoint circle rasterizer. Start and step
// items go in on the req_ stream. A local copy of the circle walk predicts
// the eight points that each live step must give, and every point on the
// rsp_ stream is checked against the oldest prediction. A short directed
// table comes first, then random circles under three idling patterns.
// ---------------------------------------------------------------------------

module midpoint_circle_rasterizer_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   import mcr_pkg::*;

   localparam int unsigned COORD_BITS  = 16;
   localparam int unsigned RADIUS_BITS = 12;
   localparam int unsigned REQ_W       = ((2*COORD_BITS+RADIUS_BITS+7)/8)*8;
   localparam int unsigned RSP_W       = ((2*COORD_BITS+2+7)/8)*8;
   localparam int unsigned PT_W        = COORD_BITS + 1;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 32;   // a few times the job queue plus output stage
   localparam int PHASE_ITEMS   = 40;   // counted items per idling phase
   localparam int N_DIRECTED    = 25;

   // how the expectation of a directed row is formed
   typedef enum logic [1:0] {
      BY_WALK,       // from the local walk
      NO_POINTS,     // item must give nothing
      CENTRE_EIGHT   // radius one: eight copies of the centre, circle ends
   } row_kind_type;

   typedef struct {
      logic                         cmd;
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic [RADIUS_BITS-1:0]       r;
      row_kind_type                 kind;
   } stim_row_type;

   typedef struct {
      logic signed [PT_W-1:0] px;
      logic signed [PT_W-1:0] py;
      logic [OCT_W-1:0]       oct;
      logic                   last;
      logic                   done;
   } point_type;

   // ------------------------------------------------------------------
   // Clock, reset and the block's ports. Every input is known from time 0.
   // ------------------------------------------------------------------
   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tuser  = CMD_STEP;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic [OCT_W:0]   rsp_tuser;
   logic             rsp_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;

   always #1 clock = ~clock;

   midpoint_circle_rasterizer_top #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // ------------------------------------------------------------------
   // Local copy of the circle walk; all zero from time 0.
   // ------------------------------------------------------------------
   logic                         walk_active = 1'b0;
   logic signed [COORD_BITS-1:0] centre_x    = '0;
   logic signed [COORD_BITS-1:0] centre_y    = '0;
   logic signed [13:0]           diameter    = '0;
   logic signed [12:0]           walk_x      = '0;
   logic signed [12:0]           walk_y      = '0;  // one spare bit keeps x < y signed
   logic signed [13:0]           step_tx     = '0;
   logic signed [13:0]           step_ty     = '0;
   logic signed [15:0]           err_term    = '0;

   point_type expected_points [$];
   int        mismatch_count = 0;
   int        cycle_count    = 0;
   int        send_gap_pct   = 0;  // chance per cycle that the sender holds off
   int        recv_stall_pct = 0;  // chance per cycle that the receiver stalls

   // Applies one accepted item to the local walk. Returns the number of
   // points that it gives (0 or 8) and fills pts with them in octant order.
   function automatic int advance_walk(
      input  logic                         cmd,
      input  logic signed [COORD_BITS-1:0] cx_in,
      input  logic signed [COORD_BITS-1:0] cy_in,
      input  logic [RADIUS_BITS-1:0]       r_in,
      output point_type                    pts [0:7]
   );
      logic signed [12:0] x;
      logic signed [12:0] y;
      logic               fin;
      int                 k;
      if (cmd == CMD_START) begin
         centre_x    = cx_in;
         centre_y    = cy_in;
         diameter    = $signed({1'b0, r_in, 1'b0});
         walk_x      = $signed({1'b0, r_in}) - 13'sd1;
         walk_y      = '0;
         step_tx     = 14'sd1;
         step_ty     = 14'sd1;
         err_term    = 16'sd1 - diameter;
         walk_active = (walk_x >= walk_y);   // radius zero never goes live
         return 0;
      end
      if (!walk_active)
         return 0;
      x = walk_x;
      y = walk_y;
      if (err_term <= 0) begin
         walk_y   = walk_y + 13'sd1;
         err_term = err_term + step_ty;
         step_ty  = step_ty + 14'sd2;
      end
      if (err_term > 0) begin
         walk_x   = walk_x - 13'sd1;
         step_tx  = step_tx + 14'sd2;
         err_term = err_term + step_tx - diameter;
      end
      fin = (walk_x < walk_y);
      if (fin)
         walk_active = 1'b0;
      for (k = 0; k < 8; k++) begin
         case (k)
            0: begin pts[k].px = centre_x + x; pts[k].py = centre_y - y; end
            1: begin pts[k].px = centre_x + x; pts[k].py = centre_y + y; end
            2: begin pts[k].px = centre_x - x; pts[k].py = centre_y - y; end
            3: begin pts[k].px = centre_x - x; pts[k].py = centre_y + y; end
            4: begin pts[k].px = centre_x + y; pts[k].py = centre_y - x; end
            5: begin pts[k].px = centre_x + y; pts[k].py = centre_y + x; end
            6: begin pts[k].px = centre_x - y; pts[k].py = centre_y - x; end
            default: begin pts[k].px = centre_x - y; pts[k].py = centre_y + x; end
         endcase
         pts[k].oct  = k[OCT_W-1:0];
         pts[k].last = (k[OCT_W-1:0] == OCT_LAST);
         pts[k].done = (k[OCT_W-1:0] == OCT_LAST) && fin;
      end
      return 8;
   endfunction

   // ------------------------------------------------------------------
   // Sender. Drives at the falling edge, holds the item until the rising
   // edge that sees tvalid and tready, then books its expected points.
   // tvalid gets one assignment per falling edge, so back-to-back items
   // keep it high without a glitch.
   // ------------------------------------------------------------------
   task automatic send_item(
      input logic                         cmd,
      input logic signed [COORD_BITS-1:0] cx,
      input logic signed [COORD_BITS-1:0] cy,
      input logic [RADIUS_BITS-1:0]       r,
      input row_kind_type                 kind
   );
      point_type pts [0:7];
      int        n;
      int        k;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_W-2*COORD_BITS-RADIUS_BITS){1'b0}}, r, cy, cx};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      n = advance_walk(cmd, cx, cy, r, pts);
      case (kind)
         BY_WALK: begin
            for (k = 0; k < n; k++)
               expected_points.push_back(pts[k]);
         end
         CENTRE_EIGHT: begin
            // a radius-one circle is eight copies of the centre
            for (k = 0; k < 8; k++) begin
               pts[k].px   = PT_W'(cx);
               pts[k].py   = PT_W'(cy);
               pts[k].oct  = k[OCT_W-1:0];
               pts[k].last = (k[OCT_W-1:0] == OCT_LAST);
               pts[k].done = (k[OCT_W-1:0] == OCT_LAST);
               expected_points.push_back(pts[k]);
            end
         end
         default: ;  // NO_POINTS
      endcase
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Receiver. tready is re-rolled at every falling edge; each point taken
   // at a rising edge is checked against the oldest expectation.
   // ------------------------------------------------------------------
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin : check_points
      point_type got;
      point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.px   = rsp_tdata[PT_W-1:0];
         got.py   = rsp_tdata[2*PT_W-1:PT_W];
         got.oct  = rsp_tuser[OCT_W-1:0];
         got.done = rsp_tuser[OCT_W];
         got.last = rsp_tlast;
         if (expected_points.size() == 0) begin
            mismatch_count++;
            $display("%0t: point (%0d,%0d) oct %0d last %0b done %0b with none expected",
                     $time, got.px, got.py, got.oct, got.last, got.done);
         end else begin
            want = expected_points.pop_front();
            if (got.px !== want.px || got.py !== want.py || got.oct !== want.oct ||
                got.last !== want.last || got.done !== want.done) begin
               mismatch_count++;
               $display({"%0t: expected (%0d,%0d) oct %0d last %0b done %0b,",
                         " got (%0d,%0d) oct %0d last %0b done %0b"},
                        $time, want.px, want.py, want.oct, want.last, want.done,
                        got.px, got.py, got.oct, got.last, got.done);
            end
         end
      end
   end

   // Watchdog: far above the slowest correct run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d points outstanding",
                  $time, expected_points.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      stim_row_type           dir_rows [N_DIRECTED];
      logic                   cmd;
      logic [RADIUS_BITS-1:0] r;
      int                     phase;
      int                     counted;
      int                     sel;
      int                     step_cap;
      int                     n_steps;
      int                     i;

      // Directed table. Step rows carry junk coordinates, which the block
      // must ignore; on the radius-one rows they hold the typed centre.
      dir_rows = '{
         // step straight out of reset: idle, nothing
         '{CMD_STEP,  16'sh1234, 16'sh5678, 12'd0,    NO_POINTS},
         // radius zero never starts a walk
         '{CMD_START, 16'sh0000, 16'sh0000, 12'd0,    NO_POINTS},
         '{CMD_STEP,  16'sh7FFF, 16'sh8000, 12'hFFF,  NO_POINTS},
         // radius one at the coordinate extremes
         '{CMD_START, 16'sh8000, 16'sh7FFF, 12'd1,    NO_POINTS},
         '{CMD_STEP,  16'sh8000, 16'sh7FFF, 12'd0,    CENTRE_EIGHT},
         '{CMD_STEP,  16'sh0000, 16'sh0000, 12'd0,    NO_POINTS},   // finished
         '{CMD_START, 16'sh7FFF, 16'sh8000, 12'd1,    NO_POINTS},
         '{CMD_STEP,  16'sh7FFF, 16'sh8000, 12'hFFF,  CENTRE_EIGHT},
         // largest radius at the most negative corner
         '{CMD_START, 16'sh8000, 16'sh8000, 12'hFFF,  NO_POINTS},
         '{CMD_STEP,  16'sh0000, 16'shFFFF, 12'd0,    BY_WALK},
         '{CMD_STEP,  16'shFFFF, 16'sh0000, 12'hFFF,  BY_WALK},
         '{CMD_STEP,  16'sh5555, 16'shAAAA, 12'h555,  BY_WALK},
         '{CMD_STEP,  16'shAAAA, 16'sh5555, 12'hAAA,  BY_WALK},
         // new start abandons the running circle
         '{CMD_START, 16'sh7FFF, 16'sh7FFF, 12'hFFF,  NO_POINTS},
         '{CMD_STEP,  16'sh0000, 16'sh0000, 12'd0,    BY_WALK},
         '{CMD_STEP,  16'sh0000, 16'sh0000, 12'd0,    BY_WALK},
         '{CMD_STEP,  16'sh0000, 16'sh0000, 12'd0,    BY_WALK},
         // radius two runs to completion, then a dead step
         '{CMD_START, 16'sd100,  -16'sd200, 12'd2,    NO_POINTS},
         '{CMD_STEP,  16'sh0000, 16'sh0000, 12'd0,    BY_WALK},
         '{CMD_STEP,  16'sh0000, 16'sh0000, 12'd0,    BY_WALK},
         '{CMD_STEP,  16'sh0000, 16'sh0000, 12'd0,    NO_POINTS},
         '{CMD_START, -16'sd5,   16'sd7,    12'd3,    NO_POINTS},
         '{CMD_STEP,  16'sh0000, 16'sh0000, 12'd0,    BY_WALK},
         '{CMD_STEP,  16'sh0000, 16'sh0000, 12'd0,    BY_WALK},
         '{CMD_STEP,  16'sh0000, 16'sh0000, 12'd0,    BY_WALK}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (phase = 0; phase < 3; phase++) begin
         // sender light / receiver heavy, then swapped, then flat out
         case (phase)
            0:       begin send_gap_pct = 8;  recv_stall_pct = 80; end
            1:       begin send_gap_pct = 80; recv_stall_pct = 8;  end
            default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
         endcase

         if (phase == 0)
            for (i = 0; i < N_DIRECTED; i++)
               send_item(dir_rows[i].cmd, dir_rows[i].cx, dir_rows[i].cy,
                         dir_rows[i].r, dir_rows[i].kind);

         counted = 0;
         while (counted < PHASE_ITEMS) begin
            if ($urandom_range(99) < 15) begin
               // noise: any command with any fields
               cmd = 1'($urandom_range(1));
               if (cmd == CMD_START || walk_active)
                  counted++;
               send_item(cmd, COORD_BITS'($urandom), COORD_BITS'($urandom),
                         RADIUS_BITS'($urandom), BY_WALK);
            end else begin
               // a well-formed circle: start, steps to the end, up to two dead steps
               sel = $urandom_range(99);
               step_cap = 1 << 20;
               if (sel < 10)
                  r = RADIUS_BITS'($urandom_range(1));
               else if (sel < 92)
                  r = RADIUS_BITS'($urandom_range(16, 2));
               else begin
                  // big circles are cut short by the next start
                  r = RADIUS_BITS'($urandom_range(4095, 17));
                  step_cap = $urandom_range(10, 3);
               end
               send_item(CMD_START, COORD_BITS'($urandom), COORD_BITS'($urandom),
                         r, BY_WALK);
               counted++;
               n_steps = 0;
               while (walk_active && n_steps < step_cap) begin
                  send_item(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                            RADIUS_BITS'($urandom), BY_WALK);
                  counted++;
                  n_steps++;
               end
               if (!walk_active)
                  repeat ($urandom_range(2))
                     send_item(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                               RADIUS_BITS'($urandom), BY_WALK);
            end
         end
      end
      req_tvalid <= 1'b0;

      // let the last points out, then watch for strays
      while (expected_points.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
